>>> sv/notify_retry_until_ack_top_assert.svh
// ----------------------------------------------------------------------------
// notify_retry_until_ack_top assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef NOTIFY_RETRY_UNTIL_ACK_TOP_ASSERT_SVH
`define NOTIFY_RETRY_UNTIL_ACK_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define NRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define NRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra_pkg
// types, constants and helpers of the notify/retry/ack sender
// ----------------------------------------------------------------------------
package nra_pkg;

    localparam int TIMER_BITS = 32;

    localparam logic [15:0] HDR_MAGIC        = 16'h4352;
    localparam logic [7:0]  HDR_VERSION      = 8'd1;
    localparam logic [7:0]  MSG_NOTIFICATION = 8'd1;
    localparam logic [7:0]  MSG_ACK          = 8'd2;
    localparam logic [15:0] HDR_MIN_LEN      = 16'd16;

    localparam logic [31:0] RST_SEND_DELAY   = 32'd1900;
    localparam logic [31:0] RST_RETRY        = 32'd50;
    localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd3;
    localparam logic [31:0] RST_SEQ          = 32'd1;
    localparam logic [62:0] RST_HANDOVER     = 63'd2000000000;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_HEADER = 1'b1;

    typedef enum logic [2:0] {
        REG_SEND_DELAY = 3'd0,
        REG_RETRY      = 3'd1,
        REG_MAX_ATT    = 3'd2,
        REG_SEQ        = 3'd3,
        REG_HANDOVER   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] send_delay;
        logic [31:0] retry_interval;
        logic [7:0]  max_attempts;
        logic [31:0] seq_number;
        logic [62:0] handover_ns;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_BITS-1:0] countdown;
        logic [7:0]            attempts;
        logic                  acked;
        logic                  armed;
    } state_t;

    typedef struct packed {
        logic        op;
        logic [15:0] pkt_length;
        logic [15:0] pkt_magic;
        logic [7:0]  pkt_version;
        logic [7:0]  pkt_type;
        logic [31:0] pkt_sequence;
    } item_t;

    typedef struct packed {
        logic        send_now;
        logic [31:0] out_sequence;
        logic [62:0] out_handover_ns;
        logic [7:0]  attempt_number;
        logic        ack_accepted;
        logic        is_acknowledged;
        logic        gave_up;
    } res_t;

    // countdown load: 32-bit register value fitted to the timer width
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [31:0] v);
        logic [63:0] wide;
        wide = {32'd0, v};
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

>>> sv/nra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface nra_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] pkt_length;
    logic [15:0] pkt_magic;
    logic [7:0]  pkt_version;
    logic [7:0]  pkt_type;
    logic [31:0] pkt_sequence;

    modport source (output valid, op, pkt_length, pkt_magic, pkt_version, pkt_type,
                    pkt_sequence, input ready);
    modport sink   (input valid, op, pkt_length, pkt_magic, pkt_version, pkt_type,
                    pkt_sequence, output ready);
endinterface

interface nra_result_if;
    logic        valid;
    logic        ready;
    logic        send_now;
    logic [31:0] out_sequence;
    logic [62:0] out_handover_ns;
    logic [7:0]  attempt_number;
    logic        ack_accepted;
    logic        is_acknowledged;
    logic        gave_up;

    modport source (output valid, send_now, out_sequence, out_handover_ns,
                    attempt_number, ack_accepted, is_acknowledged, gave_up,
                    input ready);
    modport sink   (input valid, send_now, out_sequence, out_handover_ns,
                    attempt_number, ack_accepted, is_acknowledged, gave_up,
                    output ready);
endinterface

interface nra_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  idx;
    logic [63:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

>>> sv/nra_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra_cfg_regs
// configuration register file, one register written per transaction
// ----------------------------------------------------------------------------
module nra_cfg_regs
    import nra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_idx,
    input  logic [63:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.send_delay     <= RST_SEND_DELAY;
            cfg_reg.retry_interval <= RST_RETRY;
            cfg_reg.max_attempts   <= RST_MAX_ATTEMPTS;
            cfg_reg.seq_number     <= RST_SEQ;
            cfg_reg.handover_ns    <= RST_HANDOVER;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_SEND_DELAY: cfg_reg.send_delay     <= wr_data[31:0];
                REG_RETRY:      cfg_reg.retry_interval <= wr_data[31:0];
                REG_MAX_ATT:    cfg_reg.max_attempts   <= wr_data[7:0];
                REG_SEQ:        cfg_reg.seq_number     <= wr_data[31:0];
                REG_HANDOVER:   cfg_reg.handover_ns    <= wr_data[62:0];
                default:        ; // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/nra_ack_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra_ack_chk
// decides whether a received header is a valid matching ack
// ----------------------------------------------------------------------------
module nra_ack_chk
    import nra_pkg::*;
(
    input  item_t       item,
    input  logic [31:0] seq_number,
    output logic        ack_ok
);

    logic len_ok;
    logic type_ok;

    assign len_ok  = (item.pkt_length >= HDR_MIN_LEN);
    // a notification type is well formed but never an ack
    assign type_ok = (item.pkt_type == MSG_ACK);

    assign ack_ok = (item.op == OP_HEADER) && len_ok
                 && (item.pkt_magic == HDR_MAGIC)
                 && (item.pkt_version == HDR_VERSION)
                 && type_ok
                 && (item.pkt_sequence == seq_number);

endmodule

>>> sv/nra_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra_step
// next state and result for one tick or header
// ----------------------------------------------------------------------------
module nra_step
    import nra_pkg::*;
(
    input  item_t  item,
    input  state_t st,
    input  cfg_t   cfg,
    output state_t st_next,
    output res_t   res
);

    logic                  ack_ok;
    logic                  sent;
    logic [7:0]            eff_max;
    logic [7:0]            att_inc;
    logic [TIMER_BITS-1:0] cd_dec;

    nra_ack_chk u_ack_chk (
        .item       (item),
        .seq_number (cfg.seq_number),
        .ack_ok     (ack_ok)
    );

    // zero attempts behaves as one
    assign eff_max = (cfg.max_attempts == 8'd0) ? 8'd1 : cfg.max_attempts;
    assign att_inc = st.attempts + 8'd1;

    always_comb
    begin
        st_next = st;
        sent    = 1'b0;
        cd_dec  = st.countdown;
        if (item.op == OP_TICK)
        begin
            if (st.armed)
            begin
                if (st.countdown != '0)
                begin
                    cd_dec = st.countdown - TIMER_BITS'(1);
                end
                st_next.countdown = cd_dec;
                if (cd_dec == '0)
                begin
                    st_next.armed = 1'b0;
                    if (!st.acked && (st.attempts < eff_max))
                    begin
                        sent             = 1'b1;
                        st_next.attempts = att_inc;
                        if (att_inc < eff_max)
                        begin
                            st_next.countdown = timer_load(cfg.retry_interval);
                            st_next.armed     = 1'b1;
                        end
                    end
                end
            end
        end
        else if (ack_ok)
        begin
            st_next.acked = 1'b1;
            st_next.armed = 1'b0;
        end
    end

    always_comb
    begin
        res.send_now        = sent;
        res.out_sequence    = sent ? cfg.seq_number : 32'd0;
        res.out_handover_ns = sent ? cfg.handover_ns : 63'd0;
        res.attempt_number  = st_next.attempts;
        res.ack_accepted    = ack_ok;
        res.is_acknowledged = st_next.acked;
        res.gave_up         = !st_next.acked && (st_next.attempts >= eff_max);
    end

endmodule

>>> sv/notify_retry_until_ack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notify_retry_until_ack_top
// sender of a notification that retries on a tick timer until acknowledged
// ----------------------------------------------------------------------------
//  channel   dir   handshake      moves
//  item      in    valid/ready    one tick or one received header
//  result    out   valid/ready    one result per item
//  cfg       in    valid/ready    one register write (idx, data)
//
//  one item per cycle sustained while results are taken; an accepted item
//  passes through the input register, then the result register, where its
//  result is presented
//  the state update and result sit in the single pass between the two
//  registers, so each item sees the state left by the one before it
//  rst_n is asynchronous, active low: configuration registers, countdown and flags reload
//  a stalled result holds; the input register keeps filling, and item.ready
//  drops only once both registers are full
//  cfg writes are always taken (cfg.ready is high)
// ----------------------------------------------------------------------------
module notify_retry_until_ack_top
    import nra_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    nra_item_if.sink      item,
    nra_result_if.source  result,
    nra_cfg_if.sink       cfg
);

    // configuration registers
    cfg_t   cfg_q;
    logic   cfg_wr;

    // pipeline registers
    logic   in_vld_reg;
    item_t  in_item_reg;
    logic   res_vld_reg;
    res_t   res_reg;

    // sender state
    state_t st_reg;
    state_t st_next;
    res_t   res_next;

    logic   advance;
    logic   in_take;
    item_t  item_bus;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    nra_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr),
        .wr_idx  (cfg.idx),
        .wr_data (cfg.data),
        .cfg     (cfg_q)
    );

    // item in the input register moves on when the result slot frees up
    assign advance    = in_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || advance;
    assign in_take    = item.valid && item.ready;

    assign item_bus.op           = item.op;
    assign item_bus.pkt_length   = item.pkt_length;
    assign item_bus.pkt_magic    = item.pkt_magic;
    assign item_bus.pkt_version  = item.pkt_version;
    assign item_bus.pkt_type     = item.pkt_type;
    assign item_bus.pkt_sequence = item.pkt_sequence;

    nra_step u_step (
        .item    (in_item_reg),
        .st      (st_reg),
        .cfg     (cfg_q),
        .st_next (st_next),
        .res     (res_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_vld_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= item_bus;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // sender state: committed as the item passes into the result register;
    // else a send delay write before any send or ack reloads and arms the timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.countdown <= timer_load(RST_SEND_DELAY);
            st_reg.attempts  <= 8'd0;
            st_reg.acked     <= 1'b0;
            st_reg.armed     <= 1'b1;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
        else if (cfg_wr && (cfg.idx == REG_SEND_DELAY)
                 && (st_reg.attempts == 8'd0) && !st_reg.acked)
        begin
            st_reg.countdown <= timer_load(cfg.data[31:0]);
            st_reg.armed     <= 1'b1;
        end
    end

    assign result.valid           = res_vld_reg;
    assign result.send_now        = res_reg.send_now;
    assign result.out_sequence    = res_reg.out_sequence;
    assign result.out_handover_ns = res_reg.out_handover_ns;
    assign result.attempt_number  = res_reg.attempt_number;
    assign result.ack_accepted    = res_reg.ack_accepted;
    assign result.is_acknowledged = res_reg.is_acknowledged;
    assign result.gave_up         = res_reg.gave_up;

endmodule

>>> sv/nra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nra_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "notify_retry_until_ack_top_assert.svh"

module nra_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        send_now,
    input  logic [31:0] out_sequence,
    input  logic [62:0] out_handover_ns,
    input  logic [7:0]  attempt_number,
    input  logic        ack_accepted,
    input  logic        is_acknowledged,
    input  logic        gave_up
);

    logic       res_take;
    logic       seen_reg;
    logic       ack_seen_reg;
    logic       ack_seen_next;
    logic [7:0] last_att_reg;

    assign res_take      = res_valid && res_ready;
    assign ack_seen_next = ack_seen_reg || is_acknowledged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            ack_seen_reg <= 1'b0;
            last_att_reg <= 8'd0;
        end
        else if (res_take)
        begin
            seen_reg     <= 1'b1;
            ack_seen_reg <= ack_seen_next;
            last_att_reg <= attempt_number;
        end
    end

    `NRA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(send_now) && $stable(out_sequence) && $stable(out_handover_ns) && $stable(attempt_number) && $stable(ack_accepted) && $stable(is_acknowledged) && $stable(gave_up), "result changed while stalled")
    `NRA_ASSERT_SAME(a_ack_sticky, res_valid && ack_seen_reg, is_acknowledged, "acknowledge flag cleared")
    `NRA_ASSERT_SAME(a_att_mono, res_valid && seen_reg, attempt_number >= last_att_reg, "attempt count went down")
    `NRA_ASSERT_SAME(a_send_sane, res_valid && send_now, !is_acknowledged && !ack_accepted && attempt_number != 8'd0, "send after ack or with zero attempts")

endmodule

bind notify_retry_until_ack_top nra_checker u_nra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .send_now        (result.send_now),
    .out_sequence    (result.out_sequence),
    .out_handover_ns (result.out_handover_ns),
    .attempt_number  (result.attempt_number),
    .ack_accepted    (result.ack_accepted),
    .is_acknowledged (result.is_acknowledged),
    .gave_up         (result.gave_up)
);

>>> sim/notify_retry_until_ack_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notify_retry_until_ack_top_test
// self-checking bench for the notify/retry/ack sender: a running model of the
// countdown, attempt count and ack flag predicts one result per item, and
// every result leaving the block is compared field by field against it
// ----------------------------------------------------------------------------
module notify_retry_until_ack_top_test;
    import nra_pkg::*;

    localparam logic [2:0] REG_UNUSED  = 3'd5;   // index with no register behind it
    localparam int         HOLD_CYCLES = 48;     // long receiver hold-off
    localparam int         QUIET_LIMIT = 1000;   // cycles with no transaction at all

    // ------------------------------------------------------------------------
    // expected-result ledger: mirror of the sender state plus pending results
    // ------------------------------------------------------------------------
    class notice_ledger;
        cfg_t                  regs;
        logic [TIMER_BITS-1:0] countdown;
        logic [7:0]            attempts;
        logic                  acked;
        logic                  armed;
        res_t                  due_results[$];
        int items_in, results_seen, sends_seen, acks_seen, giveups_seen;
        int writes, errors;

        function new();
            regs.send_delay     = RST_SEND_DELAY;
            regs.retry_interval = RST_RETRY;
            regs.max_attempts   = RST_MAX_ATTEMPTS;
            regs.seq_number     = RST_SEQ;
            regs.handover_ns    = RST_HANDOVER;
            countdown = RST_SEND_DELAY;
            attempts  = '0;
            acked     = 1'b0;
            armed     = 1'b1;
        endfunction

        // register write as the block applies it
        function void write_reg(input logic [2:0] idx, input logic [63:0] data);
            writes++;
            case (idx)
                REG_SEND_DELAY:
                begin
                    regs.send_delay = data[31:0];
                    // reload only before the first notification and before any ack
                    if (attempts == 0 && !acked)
                    begin
                        countdown = data[31:0];
                        armed     = 1'b1;
                    end
                end
                REG_RETRY:    regs.retry_interval = data[31:0];
                REG_MAX_ATT:  regs.max_attempts   = data[7:0];
                REG_SEQ:      regs.seq_number     = data[31:0];
                REG_HANDOVER: regs.handover_ns    = data[62:0];
                default:      ;
            endcase
        endfunction

        // advance the model by one accepted item and queue its result
        function void take_item(input item_t it);
            res_t       r;
            logic [7:0] limit;
            logic       sent, hit;
            limit = (regs.max_attempts == 0) ? 8'd1 : regs.max_attempts;
            sent  = 1'b0;
            hit   = 1'b0;
            items_in++;
            if (it.op == OP_TICK)
            begin
                if (armed)
                begin
                    if (countdown != 0)
                        countdown = countdown - 1'b1;
                    if (countdown == 0)
                    begin
                        armed = 1'b0;
                        if (!acked && attempts < limit)
                        begin
                            sent     = 1'b1;
                            attempts = attempts + 1'b1;
                            if (attempts < limit)
                            begin
                                countdown = regs.retry_interval;
                                armed     = 1'b1;
                            end
                        end
                    end
                end
            end
            else if (it.pkt_length >= HDR_MIN_LEN && it.pkt_magic == HDR_MAGIC &&
                     it.pkt_version == HDR_VERSION && it.pkt_type == MSG_ACK &&
                     it.pkt_sequence == regs.seq_number)
            begin
                hit   = 1'b1;
                acked = 1'b1;
                armed = 1'b0;
            end
            r.send_now        = sent;
            r.out_sequence    = sent ? regs.seq_number : '0;
            r.out_handover_ns = sent ? regs.handover_ns : '0;
            r.attempt_number  = attempts;
            r.ack_accepted    = hit;
            r.is_acknowledged = acked;
            r.gave_up         = !acked && attempts >= limit;
            due_results.push_back(r);
        endfunction

        function void flag_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        // compare one result from the block against the oldest expectation
        function void match_result(input res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            results_seen++;
            sends_seen   += want.send_now;
            acks_seen    += want.ack_accepted;
            giveups_seen += want.gave_up;
            flag_field("send_now",        want.send_now,        got.send_now);
            flag_field("out_sequence",    want.out_sequence,    got.out_sequence);
            flag_field("out_handover_ns", want.out_handover_ns, got.out_handover_ns);
            flag_field("attempt_number",  want.attempt_number,  got.attempt_number);
            flag_field("ack_accepted",    want.ack_accepted,    got.ack_accepted);
            flag_field("is_acknowledged", want.is_acknowledged, got.is_acknowledged);
            flag_field("gave_up",         want.gave_up,         got.gave_up);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nra_item_if   item_if();
    nra_result_if result_if();
    nra_cfg_if    cfg_if();

    notice_ledger ledger = new();

    // traffic shaping flags, all owned by the stimulus process
    logic calm      = 1'b0;  // no idling on either side
    logic steady_tx = 1'b0;  // sender offers back to back
    logic hold_rx   = 1'b0;  // receiver to start a long hold-off
    int   holds_done = 0;

    notify_retry_until_ack_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic item_t hdr(input logic [15:0] len, input logic [15:0] mag,
                                  input logic [7:0] ver, input logic [7:0] typ,
                                  input logic [31:0] sq);
        item_t it;
        it.op           = OP_HEADER;
        it.pkt_length   = len;
        it.pkt_magic    = mag;
        it.pkt_version  = ver;
        it.pkt_type     = typ;
        it.pkt_sequence = sq;
        return it;
    endfunction

    // tick or header with every field random
    function automatic item_t noise_item(input logic op);
        item_t it;
        it    = hdr(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
        it.op = op;
        return it;
    endfunction

    function automatic item_t good_ack(input logic [31:0] sq);
        return hdr(16'($urandom_range(16, 65535)), HDR_MAGIC, HDR_VERSION, MSG_ACK, sq);
    endfunction

    // ack-shaped header with exactly one field spoilt
    function automatic item_t broken_ack(input logic [31:0] sq);
        item_t it;
        it = good_ack(sq);
        case ($urandom_range(0, 5))
            0: it.pkt_length   = 16'($urandom_range(0, 15));
            1: it.pkt_magic    = HDR_MAGIC ^ 16'($urandom_range(1, 65535));
            2: it.pkt_version  = HDR_VERSION ^ 8'($urandom_range(1, 255));
            3: it.pkt_type     = MSG_NOTIFICATION;
            4: it.pkt_type     = MSG_ACK ^ 8'($urandom_range(1, 255));
            default: it.pkt_sequence = sq ^ $urandom_range(1, 32'hFFFF_FFFF);
        endcase
        return it;
    endfunction

    // header unlikely to be a matching ack: a broken ack or random fields
    function automatic item_t stray_header();
        if ($urandom_range(0, 2) == 0)
            return noise_item(OP_HEADER);
        return broken_ack(ledger.regs.seq_number);
    endfunction

    // retry interval, mostly short so the attempts keep coming; junk upper bits
    function automatic logic [63:0] retry_word();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'd0;
            6:       v = $urandom_range(5, 12);
            default: v = $urandom_range(1, 4);
        endcase
        return {32'($urandom), v};
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    // offer one item; ready is stable from the falling edge to the next rising one
    task automatic send(input item_t it);
        logic taken;
        if (!calm && !steady_tx && $urandom_range(0, 4) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.op           <= it.op;
        item_if.pkt_length   <= it.pkt_length;
        item_if.pkt_magic    <= it.pkt_magic;
        item_if.pkt_version  <= it.pkt_version;
        item_if.pkt_type     <= it.pkt_type;
        item_if.pkt_sequence <= it.pkt_sequence;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = item_if.ready;
            @(posedge clk);
        end
        ledger.take_item(it);
    endtask

    // one register write; the caller drops cfg valid after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        logic taken;
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_if.ready;
            @(posedge clk);
        end
        ledger.write_reg(idx, data);
    endtask

    // stop offering and wait until every outstanding result has been taken
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (ledger.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random ready bursts, stall bursts and the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        result_if.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_rx)
            begin
                // hold-off counted here, the sender keeps offering meanwhile
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
                holds_done++;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // results are sampled mid-cycle, where everything is settled
    initial
    begin : result_monitor
        res_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got.send_now        = result_if.send_now;
                got.out_sequence    = result_if.out_sequence;
                got.out_handover_ns = result_if.out_handover_ns;
                got.attempt_number  = result_if.attempt_number;
                got.ack_accepted    = result_if.ack_accepted;
                got.is_acknowledged = result_if.is_acknowledged;
                got.gave_up         = result_if.gave_up;
                ledger.match_result(got);
            end
        end
    end

    // watchdog: too long with no transaction on any channel ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (item_if.valid && item_if.ready) ||
                (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL notify_retry_until_ack_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        item_t it;
        int    ph, n;
        logic  hdr_only;

        rst_n                = 1'b0;
        item_if.valid        <= 1'b0;
        item_if.op           <= OP_TICK;
        item_if.pkt_length   <= '0;
        item_if.pkt_magic    <= '0;
        item_if.pkt_version  <= '0;
        item_if.pkt_type     <= '0;
        item_if.pkt_sequence <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.idx           <= REG_SEND_DELAY;
        cfg_if.data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // -- directed: extremes of every register, timer far from firing ----
        write_reg(REG_UNUSED,     64'hFFFF_FFFF_FFFF_FFFF);   // ignored index
        write_reg(REG_SEND_DELAY, 64'hFFFF_FFFF_FFFF_FFFF);   // reloads the countdown
        write_reg(REG_RETRY,      64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MAX_ATT,    64'hFFFF_FFFF_FFFF_FF00);   // zero, acts as one
        write_reg(REG_SEQ,        64'h0000_0000_FFFF_FFFF);
        write_reg(REG_HANDOVER,   64'hFFFF_FFFF_FFFF_FFFF);   // top bit dropped
        cfg_if.valid <= 1'b0;

        it    = hdr('1, '1, '1, '1, '1);
        it.op = OP_TICK;
        send(it);                                              // tick, payload all ones
        it    = hdr('0, '0, '0, '0, '0);
        it.op = OP_TICK;
        send(it);                                              // tick, payload all zeros
        send(hdr('0, '0, '0, '0, '0));
        send(hdr('1, '1, '1, '1, '1));
        // one field short of an ack each time
        send(hdr(16'd15, HDR_MAGIC, HDR_VERSION, MSG_ACK, 32'hFFFF_FFFF));
        send(hdr(16'd16, HDR_MAGIC ^ 16'd1, HDR_VERSION, MSG_ACK, 32'hFFFF_FFFF));
        send(hdr(16'd16, HDR_MAGIC, 8'd0, MSG_ACK, 32'hFFFF_FFFF));
        send(hdr(16'd16, HDR_MAGIC, 8'd2, MSG_ACK, 32'hFFFF_FFFF));
        send(hdr(16'd16, HDR_MAGIC, HDR_VERSION, MSG_NOTIFICATION, 32'hFFFF_FFFF));
        send(hdr(16'd16, HDR_MAGIC, HDR_VERSION, 8'd0, 32'hFFFF_FFFF));
        send(hdr(16'hFFFF, HDR_MAGIC, HDR_VERSION, MSG_ACK, 32'd0));
        send(hdr(16'hFFFF, HDR_MAGIC, HDR_VERSION, 8'd3, 32'hFFFF_FFFF));
        settle();

        // zero send delay fires on the first tick, zero retry on every tick after
        write_reg(REG_MAX_ATT,    64'd255);
        write_reg(REG_RETRY,      64'd0);
        write_reg(REG_SEQ,        64'd0);
        write_reg(REG_SEND_DELAY, 64'd0);
        cfg_if.valid <= 1'b0;
        repeat (3) send(noise_item(OP_TICK));
        send(hdr(16'd16, HDR_MAGIC, HDR_VERSION, MSG_ACK, 32'd1));
        settle();

        // send delay after the first notification only changes the register
        write_reg(REG_SEND_DELAY, 64'd7);
        write_reg(REG_RETRY,      64'd2);
        write_reg(REG_HANDOVER,   64'd0);
        cfg_if.valid <= 1'b0;
        repeat (5) send(noise_item(OP_TICK));

        // -- random phases: mostly ticks, stray headers mixed in, no real ack -
        for (ph = 0; ph < 24; ph++)
        begin
            settle();
            hdr_only = (ph % 8 == 5);
            write_reg(REG_RETRY,    retry_word());
            write_reg(REG_SEQ,      {32'($urandom), 32'($urandom)});
            write_reg(REG_HANDOVER, {32'($urandom), 32'($urandom)});
            if (ph % 3 == 0)
                write_reg(REG_SEND_DELAY, {32'($urandom), 32'($urandom)});
            if (ph % 7 == 2)
                write_reg(3'($urandom_range(5, 7)), {32'($urandom), 32'($urandom)});
            // header-only phases lower the limit so gave_up shows while still armed
            if (hdr_only)
                write_reg(REG_MAX_ATT,
                          {56'($urandom), 8'($urandom_range(0, ledger.attempts))});
            else
                write_reg(REG_MAX_ATT, {56'($urandom), 8'd255});
            cfg_if.valid <= 1'b0;

            steady_tx = (ph % 4 == 1) || (ph == 6);
            if (ph == 6)
                hold_rx = 1'b1;     // block fills and stalls its input

            for (n = 0; n < 33; n++)
            begin
                if (hdr_only || $urandom_range(0, 9) < 3)
                    it = stray_header();
                else
                    it = noise_item(OP_TICK);
                send(it);
                // sender pause mid-phase until everything has drained
                if (ph == 10 && n == 16)
                    settle();
            end
            steady_tx = 1'b0;
        end

        // -- closing: no idling from here on ------------------------------------
        settle();
        calm = 1'b1;
        // limit lowered to zero: already reached, so no further notifications
        write_reg(REG_MAX_ATT, {56'($urandom), 8'd0});
        cfg_if.valid <= 1'b0;
        repeat (3) send(noise_item(OP_TICK));
        send(good_ack(ledger.regs.seq_number));          // ack after giving up
        send(good_ack(ledger.regs.seq_number));          // repeated ack
        send(broken_ack(ledger.regs.seq_number));
        send(noise_item(OP_TICK));
        settle();

        // acknowledged: send delay and a raised limit bring no more sends
        write_reg(REG_SEND_DELAY, 64'd1);
        write_reg(REG_MAX_ATT,    64'd255);
        write_reg(REG_RETRY,      64'd1);
        cfg_if.valid <= 1'b0;
        for (n = 0; n < 16; n++)
        begin
            case ($urandom_range(0, 3))
                0:       it = good_ack(ledger.regs.seq_number);
                1:       it = stray_header();
                default: it = noise_item(OP_TICK);
            endcase
            send(it);
        end

        settle();
        repeat (8) @(posedge clk);
        $display("run covered %0d items, %0d results checked, %0d register writes",
                 ledger.items_in, ledger.results_seen, ledger.writes);
        $display("with %0d notifications, %0d acks taken, %0d given-up results, %0d hold-offs",
                 ledger.sends_seen, ledger.acks_seen, ledger.giveups_seen, holds_done);
        if (ledger.errors == 0)
            $display("PASS notify_retry_until_ack_top");
        else
            $display("FAIL notify_retry_until_ack_top");
        $finish;
    end

endmodule

>>> notify_retry_until_ack_top.f
+incdir+sv
sv/nra_pkg.sv
sv/nra_if.sv
sv/nra_cfg_regs.sv
sv/nra_ack_chk.sv
sv/nra_step.sv
sv/notify_retry_until_ack_top.sv
sv/nra_checker.sv
sim/notify_retry_until_ack_top_test.sv
